@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/asss_pkg.sv @@
// ----------------------------------------------------------------------------
// Axis sequencer package
// Types and constants shared by the axis start/stop sequencer and its
// channel interfaces.
// ----------------------------------------------------------------------------
package asss_pkg;

    localparam int OPCODE_W      = 2;
    localparam int AXIS_STATE_W  = 3;
    localparam int PULSE_TICKS_W = 16;

    localparam logic [PULSE_TICKS_W-1:0] PULSE_TICKS_RESET = 16'd100;

    localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_MOVE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_ABORT = 2'd2;

    localparam logic DIR_LEFT = 1'b0;

    typedef enum logic [AXIS_STATE_W-1:0] {
        ST_IDLE     = 3'd0,
        ST_HOME     = 3'd1,
        ST_STARTING = 3'd2,
        ST_MOVING   = 3'd3,
        ST_STOPPING = 3'd4,
        ST_ABORTING = 3'd5
    } axis_state_t;

    typedef logic [OPCODE_W-1:0] opcode_t;

    typedef struct packed {
        axis_state_t axis_state;
        logic        state_changed;
        logic        start_pulse;
        logic        stop_pulse;
        logic        dir_level;
        logic        accepted;
    } rsp_t;

endpackage

@@ rtl/core/asss_cmd_if.sv @@
// ----------------------------------------------------------------------------
// Axis sequencer command channel
// Valid/ready channel carrying one command transaction per handshake.
// ----------------------------------------------------------------------------
interface asss_cmd_if;
    import asss_pkg::*;

    logic    valid;
    logic    ready;
    opcode_t opcode;
    logic    direction;
    logic    end_stop;

    modport source (output valid, output opcode, output direction, output end_stop,
                    input ready);
    modport sink   (input valid, input opcode, input direction, input end_stop,
                    output ready);
endinterface

@@ rtl/core/asss_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Axis sequencer status channel
// Valid/ready channel carrying one status transaction per handshake.
// ----------------------------------------------------------------------------
interface asss_rsp_if;
    import asss_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [AXIS_STATE_W-1:0] axis_state;
    logic                    state_changed;
    logic                    start_pulse;
    logic                    stop_pulse;
    logic                    dir_level;
    logic                    accepted;

    modport source (output valid, output axis_state, output state_changed,
                    output start_pulse, output stop_pulse, output dir_level,
                    output accepted, input ready);
    modport sink   (input valid, input axis_state, input state_changed,
                    input start_pulse, input stop_pulse, input dir_level,
                    input accepted, output ready);
endinterface

@@ rtl/core/axis_start_stop_sequencer.sv @@
// ----------------------------------------------------------------------------
// Axis start/stop sequencer
// Steps one motor axis through idle, home, starting, moving, stopping and
// aborting, timing the start and stop command pulses in ticks.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Carries
//  -------   ---   ----------------------------------------------------------
//  cmd       in    opcode (tick / move / abort), direction, end_stop
//  rsp       out   axis_state, state_changed, start_pulse, stop_pulse,
//                  dir_level, accepted
//  cfg       in    pulse_ticks write (cfg_wr_en, cfg_wr_data)
//
//  Each command transaction is decoded as it is accepted: the axis state updates
//  at the accepting edge and its status goes to the output register, valid in
//  the next cycle. Sustained rate is one transaction per cycle while rsp is ready.
//  cmd.ready is high while the output register is empty or being drained, so
//  a stall on rsp holds back cmd only once the output register is full.
//  Reset is asynchronous, active low; pulse_ticks resets to 100.
//
module axis_start_stop_sequencer #(
    parameter int PULSE_COUNT_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    asss_cmd_if.sink                           cmd,
    asss_rsp_if.source                         rsp,
    input  logic                               cfg_wr_en,
    input  logic [asss_pkg::PULSE_TICKS_W-1:0] cfg_wr_data
);
    import asss_pkg::*;

    localparam int CNT_W = PULSE_COUNT_BITS;
    localparam int CMP_W = (CNT_W > PULSE_TICKS_W) ? CNT_W : PULSE_TICKS_W;

    localparam logic [CNT_W-1:0] CNT_ZERO = '0;
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CMP_W-1:0] CNT_MAX  = CMP_W'({CNT_W{1'b1}});

    logic [PULSE_TICKS_W-1:0] pulse_ticks_reg;

    axis_state_t      mode_reg,      mode_next;
    logic             dir_reg,       dir_next;
    logic             ignore_reg,    ignore_next;
    logic [CNT_W-1:0] start_cnt_reg, start_cnt_next;
    logic [CNT_W-1:0] stop_cnt_reg,  stop_cnt_next;
    logic             accepted_next;

    logic             rsp_valid_reg;
    rsp_t             rsp_reg,       rsp_next;

    logic             fire;
    logic             busy;
    logic             rest;
    logic             blocked;
    logic [CMP_W-1:0] ticks_ext;
    logic [CNT_W-1:0] load_len;

    // Pulse length saturates when the counter is narrower than the register.
    assign ticks_ext = CMP_W'(pulse_ticks_reg);
    assign load_len  = (ticks_ext > CNT_MAX) ? CNT_MAX[CNT_W-1:0] : ticks_ext[CNT_W-1:0];

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = cmd.valid && cmd.ready;

    assign busy    = (start_cnt_reg != CNT_ZERO) || (stop_cnt_reg != CNT_ZERO);
    assign rest    = (mode_reg == ST_IDLE) || (mode_reg == ST_HOME);
    assign blocked = (cmd.direction == dir_reg) && ((mode_reg == ST_HOME) || cmd.end_stop);

    // Next state
    always_comb
    begin
        mode_next      = mode_reg;
        dir_next       = dir_reg;
        ignore_next    = ignore_reg;
        start_cnt_next = start_cnt_reg;
        stop_cnt_next  = stop_cnt_reg;
        accepted_next  = 1'b0;

        unique case (cmd.opcode)
            OP_TICK:
            begin
                if (start_cnt_reg != CNT_ZERO)
                begin
                    start_cnt_next = start_cnt_reg - CNT_ONE;
                end
                if (stop_cnt_reg != CNT_ZERO)
                begin
                    stop_cnt_next = stop_cnt_reg - CNT_ONE;
                end
                // Transitions wait until both pulses have run out on this tick.
                if ((start_cnt_next == CNT_ZERO) && (stop_cnt_next == CNT_ZERO))
                begin
                    if (ignore_reg && !cmd.end_stop)
                    begin
                        ignore_next = 1'b0;
                    end
                    unique case (mode_reg)
                        ST_STARTING: mode_next = ST_MOVING;
                        ST_STOPPING: mode_next = ST_HOME;
                        ST_ABORTING: mode_next = ST_IDLE;
                        ST_MOVING:
                        begin
                            if (cmd.end_stop && !ignore_next)
                            begin
                                stop_cnt_next = load_len;
                                mode_next     = ST_STOPPING;
                            end
                        end
                        default: mode_next = mode_reg;
                    endcase
                end
            end
            OP_MOVE:
            begin
                if (rest && !busy && !blocked)
                begin
                    if (cmd.end_stop)
                    begin
                        ignore_next = 1'b1;
                    end
                    dir_next       = cmd.direction;
                    start_cnt_next = load_len;
                    mode_next      = ST_STARTING;
                    accepted_next  = 1'b1;
                end
            end
            OP_ABORT:
            begin
                if ((mode_reg == ST_MOVING) && !busy)
                begin
                    stop_cnt_next = load_len;
                    mode_next     = ST_ABORTING;
                    accepted_next = 1'b1;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        rsp_next.axis_state    = mode_next;
        rsp_next.state_changed = (mode_next != mode_reg);
        rsp_next.start_pulse   = (start_cnt_next != CNT_ZERO);
        rsp_next.stop_pulse    = (stop_cnt_next != CNT_ZERO);
        rsp_next.dir_level     = dir_next;
        rsp_next.accepted      = accepted_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_ticks_reg <= PULSE_TICKS_RESET;
        end
        else if (cfg_wr_en)
        begin
            pulse_ticks_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= ST_IDLE;
            dir_reg       <= DIR_LEFT;
            ignore_reg    <= 1'b0;
            start_cnt_reg <= CNT_ZERO;
            stop_cnt_reg  <= CNT_ZERO;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                mode_reg      <= mode_next;
                dir_reg       <= dir_next;
                ignore_reg    <= ignore_next;
                start_cnt_reg <= start_cnt_next;
                stop_cnt_reg  <= stop_cnt_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.axis_state    = rsp_reg.axis_state;
    assign rsp.state_changed = rsp_reg.state_changed;
    assign rsp.start_pulse   = rsp_reg.start_pulse;
    assign rsp.stop_pulse    = rsp_reg.stop_pulse;
    assign rsp.dir_level     = rsp_reg.dir_level;
    assign rsp.accepted      = rsp_reg.accepted;

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_one_pulse, !((start_cnt_reg != CNT_ZERO) && (stop_cnt_reg != CNT_ZERO)), "start and stop pulses overlap")
    `ASSERT_IMPLIES(a_start_in_starting, start_cnt_reg != CNT_ZERO, mode_reg == ST_STARTING, "start pulse outside starting")
    `ASSERT_IMPLIES(a_stop_in_stopping, stop_cnt_reg != CNT_ZERO, (mode_reg == ST_STOPPING) || (mode_reg == ST_ABORTING), "stop pulse outside stopping or aborting")
    `ASSERT_NEXT(a_accept_moves, fire && accepted_next, (mode_reg == ST_STARTING) || (mode_reg == ST_ABORTING), "accepted request left no start or abort")

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis start/stop sequencer testbench
// Sends tick, move and abort transactions through the command channel, works
// out the status each one should produce with an in-bench model of the axis,
// and checks every status transaction field by field and in order. Both
// channels idle and stall at random. The pulse length is swept across its
// range, including zero and the largest value.
// ----------------------------------------------------------------------------
module tb;
    import asss_pkg::*;

    localparam opcode_t OP_UNDEFINED = 2'd3;
    localparam logic    DIR_RIGHT    = 1'b1;
    localparam int      MAX_REPORTS  = 10;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [PULSE_TICKS_W-1:0] cfg_wr_data;

    asss_cmd_if cmd_if ();
    asss_rsp_if rsp_if ();

    axis_start_stop_sequencer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_if),
        .rsp         (rsp_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Axis model state and its copy of the pulse length register.
    axis_state_t              track_mode   = ST_IDLE;
    logic                     track_dir    = DIR_LEFT;
    logic                     track_ignore = 1'b0;
    logic [PULSE_TICKS_W-1:0] start_ticks  = '0;
    logic [PULSE_TICKS_W-1:0] stop_ticks   = '0;
    logic [PULSE_TICKS_W-1:0] pulse_len    = PULSE_TICKS_RESET;

    rsp_t pending_status[$];
    int   fault_count = 0;
    bit   tx_steady   = 1'b0;
    bit   rx_steady   = 1'b0;
    logic sensor      = 1'b0;

    // Advances the axis model by one command and returns the status it gives.
    function automatic rsp_t step_axis(opcode_t op, logic dir, logic es);
        rsp_t        status;
        axis_state_t prior;
        logic        took;
        logic        blocked;
        prior = track_mode;
        took  = 1'b0;
        case (op)
            OP_TICK:
            begin
                if (start_ticks != 0) start_ticks = start_ticks - 1'b1;
                if (stop_ticks != 0) stop_ticks = stop_ticks - 1'b1;
                if (start_ticks == 0 && stop_ticks == 0)
                begin
                    if (track_ignore && !es) track_ignore = 1'b0;
                    case (track_mode)
                        ST_STARTING: track_mode = ST_MOVING;
                        ST_STOPPING: track_mode = ST_HOME;
                        ST_ABORTING: track_mode = ST_IDLE;
                        ST_MOVING:
                        begin
                            if (es && !track_ignore)
                            begin
                                stop_ticks = pulse_len;
                                track_mode = ST_STOPPING;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_MOVE:
            begin
                blocked = (dir == track_dir) && (track_mode == ST_HOME || es);
                if ((track_mode == ST_IDLE || track_mode == ST_HOME) &&
                    start_ticks == 0 && stop_ticks == 0 && !blocked)
                begin
                    if (es) track_ignore = 1'b1;
                    track_dir   = dir;
                    start_ticks = pulse_len;
                    track_mode  = ST_STARTING;
                    took        = 1'b1;
                end
            end
            OP_ABORT:
            begin
                if (track_mode == ST_MOVING && start_ticks == 0 && stop_ticks == 0)
                begin
                    stop_ticks = pulse_len;
                    track_mode = ST_ABORTING;
                    took       = 1'b1;
                end
            end
            default: ;
        endcase
        status.axis_state    = track_mode;
        status.state_changed = (track_mode != prior);
        status.start_pulse   = (start_ticks != 0);
        status.stop_pulse    = (stop_ticks != 0);
        status.dir_level     = track_dir;
        status.accepted      = took;
        return status;
    endfunction

    task automatic check_status();
        rsp_t want;
        if (pending_status.size() == 0)
        begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
                $display("%0t: status transaction with nothing outstanding", $realtime);
        end
        else
        begin
            want = pending_status.pop_front();
            if (rsp_if.axis_state !== want.axis_state ||
                rsp_if.state_changed !== want.state_changed ||
                rsp_if.start_pulse !== want.start_pulse ||
                rsp_if.stop_pulse !== want.stop_pulse ||
                rsp_if.dir_level !== want.dir_level ||
                rsp_if.accepted !== want.accepted)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display({"%0t: status differs: expected state=%0d chg=%b start=%b stop=%b ",
                              "dir=%b acc=%b, got state=%0d chg=%b start=%b stop=%b dir=%b acc=%b"},
                             $realtime, want.axis_state, want.state_changed,
                             want.start_pulse, want.stop_pulse, want.dir_level, want.accepted,
                             rsp_if.axis_state, rsp_if.state_changed, rsp_if.start_pulse,
                             rsp_if.stop_pulse, rsp_if.dir_level, rsp_if.accepted);
            end
        end
    endtask

    // Results are checked before the new command is modelled, so a status that
    // appears in the same cycle as its own command is caught as unexpected.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
                check_status();
            if (cmd_if.valid && cmd_if.ready)
                pending_status.push_back(step_axis(cmd_if.opcode, cmd_if.direction,
                                                   cmd_if.end_stop));
        end
    end

    // Status side back-pressure: mostly ready, with short and occasional long stalls.
    initial
    begin
        int burst;
        rsp_if.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (rx_steady || $urandom_range(0, 99) < 60)
            begin
                rsp_if.ready <= 1'b1;
                burst = $urandom_range(1, 20);
            end
            else
            begin
                rsp_if.ready <= 1'b0;
                burst = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                   : $urandom_range(10, 40);
            end
            repeat (burst) @(posedge clk);
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (tx_steady || roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Sends one command transaction and then idles for a random gap. Valid is
    // left high when there is no gap so that back-to-back transactions follow.
    task automatic issue(opcode_t op, logic dir, logic es);
        int gap;
        cmd_if.valid     <= 1'b1;
        cmd_if.opcode    <= op;
        cmd_if.direction <= dir;
        cmd_if.end_stop  <= es;
        do @(posedge clk); while (!cmd_if.ready);
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic tick(logic es);
        issue(OP_TICK, 1'($urandom_range(0, 1)), es);
    endtask

    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        do @(posedge clk); while (pending_status.size() != 0);
    endtask

    task automatic set_pulse_len(logic [PULSE_TICKS_W-1:0] len);
        wait_drained();
        repeat (2) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        pulse_len = len;
    endtask

    // The pulse length out of reset: a full start pulse, then an abort pulse.
    task automatic test_reset_pulse_length();
        issue(OP_MOVE, DIR_RIGHT, 1'b0);
        repeat (PULSE_TICKS_RESET) tick(1'b0);
        issue(OP_ABORT, DIR_LEFT, 1'b0);
        repeat (PULSE_TICKS_RESET) tick(1'b0);
    endtask

    // Every opcode, the refusal rules, the ignore flag and both ways home.
    task automatic test_directed();
        set_pulse_len(16'd2);
        tick(1'b0);
        issue(OP_UNDEFINED, DIR_RIGHT, 1'b1);
        issue(OP_ABORT, DIR_LEFT, 1'b0);
        issue(OP_MOVE, DIR_RIGHT, 1'b1);
        issue(OP_MOVE, DIR_LEFT, 1'b0);
        issue(OP_MOVE, DIR_RIGHT, 1'b0);
        issue(OP_ABORT, DIR_LEFT, 1'b0);
        repeat (2) tick(1'b0);
        issue(OP_ABORT, DIR_LEFT, 1'b0);
        issue(OP_MOVE, DIR_RIGHT, 1'b0);
        repeat (2) tick(1'b0);
        issue(OP_MOVE, DIR_RIGHT, 1'b0);
        repeat (2) tick(1'b0);
        repeat (3) tick(1'b1);
        issue(OP_MOVE, DIR_RIGHT, 1'b1);
        issue(OP_MOVE, DIR_RIGHT, 1'b0);
        issue(OP_MOVE, DIR_LEFT, 1'b1);
        repeat (3) tick(1'b1);
        tick(1'b0);
        repeat (3) tick(1'b1);
        sensor = 1'b1;
    endtask

    // With a zero length the pulses never show and transitions follow at once.
    task automatic test_zero_pulse();
        set_pulse_len(16'd0);
        issue(OP_MOVE, DIR_RIGHT, 1'b1);
        tick(1'b1);
        tick(1'b0);
        issue(OP_ABORT, DIR_RIGHT, 1'b0);
        tick(1'b0);
        issue(OP_MOVE, DIR_LEFT, 1'b0);
        tick(1'b0);
        tick(1'b1);
        tick(1'b1);
        sensor = 1'b1;
    endtask

    // The longest pulse loads in full and stays active over a run of back to
    // back ticks. The axis is left starting, so this test comes last.
    task automatic test_longest_pulse();
        tick(1'b0);
        tick(1'b0);
        issue(OP_ABORT, DIR_LEFT, 1'b0);
        tick(1'b0);
        tick(1'b0);
        set_pulse_len(16'hFFFF);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        issue(OP_MOVE, ~track_dir, 1'b0);
        repeat (20) tick(1'b0);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // One journey: leave the rest position, run, and end at the end stop, by
    // an abort, or in a burst of arbitrary commands.
    task automatic run_trip();
        int roll;
        issue(OP_MOVE, 1'($urandom_range(0, 1)), sensor);
        repeat ($urandom_range(0, 3)) tick(sensor);
        sensor = 1'b0;
        repeat (pulse_len + $urandom_range(0, 4)) tick(1'b0);
        roll = $urandom_range(0, 99);
        if (roll < 45)
        begin
            sensor = 1'b1;
            repeat (pulse_len + $urandom_range(1, 4)) tick(1'b1);
        end
        else if (roll < 80)
        begin
            issue(OP_ABORT, 1'($urandom_range(0, 1)), 1'b0);
            repeat (pulse_len + $urandom_range(1, 3)) tick(1'b0);
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                issue(opcode_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            sensor = 1'($urandom_range(0, 1));
        end
    endtask

    task automatic test_random_trips();
        logic [PULSE_TICKS_W-1:0] lengths[6];
        lengths = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd5, 16'd1};
        foreach (lengths[i])
        begin
            set_pulse_len(lengths[i]);
            tx_steady = (i == 4);
            repeat (5)
            begin
                run_trip();
                if ($urandom_range(0, 7) == 0)
                    wait_drained();
            end
        end
        tx_steady = 1'b0;
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_wr_data      <= '0;
        cmd_if.valid     <= 1'b0;
        cmd_if.opcode    <= OP_TICK;
        cmd_if.direction <= DIR_LEFT;
        cmd_if.end_stop  <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_pulse_length();
        test_directed();
        test_zero_pulse();
        test_random_trips();
        test_longest_pulse();
        wait_drained();
        repeat (4) @(posedge clk);
        if (fault_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ axis_start_stop_sequencer.f @@
+incdir+rtl/core
rtl/core/asss_pkg.sv
rtl/core/asss_cmd_if.sv
rtl/core/asss_rsp_if.sv
rtl/core/axis_start_stop_sequencer.sv
dv/tb.sv
